/* sv/rne_pkg.sv */
// ----------------------------------------------------------------------------
// rne_pkg: shared types and constants for the roman numeral encoder
// Symbol table, sequencer states and converter status used by the encoder
// top level and its decimal converter.
// ----------------------------------------------------------------------------
package rne_pkg;

	// largest value written as a roman numeral
	localparam int ROMAN_LIMIT = 3999;
	// width of a value that fits the roman range
	localparam int ROMAN_W     = 12;
	// greedy symbol table size and index width
	localparam int NUM_SYMS    = 13;
	localparam int SYM_IDX_W   = 4;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] NO_CHAR    = 8'h00;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMPTY,
		ST_ROMAN,
		ST_PAIR,
		ST_CONV,
		ST_DIGITS
	} rne_state_t;

	// status of the decimal converter
	typedef struct packed {
		logic busy;
		logic done;
	} rne_conv_stat_t;

	// weight of each greedy symbol
	function automatic logic [ROMAN_W-1:0] rne_weight(input logic [SYM_IDX_W-1:0] idx);
		logic [ROMAN_W-1:0] w;
		unique case (idx)
			4'd0:    w = 12'd1000;
			4'd1:    w = 12'd900;
			4'd2:    w = 12'd500;
			4'd3:    w = 12'd400;
			4'd4:    w = 12'd100;
			4'd5:    w = 12'd90;
			4'd6:    w = 12'd50;
			4'd7:    w = 12'd40;
			4'd8:    w = 12'd10;
			4'd9:    w = 12'd9;
			4'd10:   w = 12'd5;
			4'd11:   w = 12'd4;
			default: w = 12'd1;
		endcase
		return w;
	endfunction

	// first letter of each symbol
	function automatic logic [7:0] rne_first(input logic [SYM_IDX_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "M";
			4'd1:    c = "C";
			4'd2:    c = "D";
			4'd3:    c = "C";
			4'd4:    c = "C";
			4'd5:    c = "X";
			4'd6:    c = "L";
			4'd7:    c = "X";
			4'd8:    c = "X";
			4'd9:    c = "I";
			4'd10:   c = "V";
			4'd11:   c = "I";
			default: c = "I";
		endcase
		return c;
	endfunction

	// second letter of a subtractive pair, zero for a single letter
	function automatic logic [7:0] rne_second(input logic [SYM_IDX_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd1:    c = "M";
			4'd3:    c = "D";
			4'd5:    c = "C";
			4'd7:    c = "L";
			4'd9:    c = "X";
			4'd11:   c = "V";
			default: c = NO_CHAR;
		endcase
		return c;
	endfunction

endpackage

/* sv/rne_bcd_conv.sv */
// ----------------------------------------------------------------------------
// rne_bcd_conv: iterative binary to decimal converter
// Shift-and-add-3 conversion, one input bit per cycle, with a report of
// the most significant nonzero digit once done.
// ----------------------------------------------------------------------------
module rne_bcd_conv #(
	parameter int W      = 32,
	parameter int NDIG   = 10,
	parameter int DIDX_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [W-1:0]               value,
	output rne_pkg::rne_conv_stat_t    stat,
	output logic [NDIG*4-1:0]          digits,
	output logic [DIDX_W-1:0]          msd
);
	import rne_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]      bin_q;
	logic [NDIG*4-1:0] bcd_q;
	logic [NDIG*4-1:0] adj;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// shift sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift datapath
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[NDIG*4-2:0], bin_q[W-1]};
		end
	end

	// highest nonzero digit
	always_comb begin
		msd = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				msd = DIDX_W'(i);
			end
		end
	end

	assign digits    = bcd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* sv/roman_numeral_encoder_unit.sv */
// Converts one unsigned value per request into a run of ASCII characters on
// the output stream, last character marked by tlast. Values 1 to 3999 come
// out as a roman numeral, chosen greedily with subtractive pairs sent as two
// characters; larger values come out as decimal digits, most significant
// first; zero gives a single empty result (tuser high, tdata 0, tlast high).
// One request at a time: s_axis_tready is high only while the sequencer is
// idle. A roman value is built by the shared 12-bit compare/subtract unit,
// which walks the table and sends the characters of each symbol taken. A
// decimal value is shifted through the bit-serial decimal converter, which is
// VALUE_BITS (capped at 32) bits wide, then handed over and sent as one
// character per digit. Output backpressure stalls the sequencer; one output
// register holds the pending character.
// ----------------------------------------------------------------------------
// roman_numeral_encoder_unit: roman numeral / decimal character encoder
// Sequencer around a shared compare/subtract unit and a decimal converter.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] char_code
	output logic        m_axis_tuser,   // [0] empty_res
	output logic        m_axis_tlast
);
	import rne_pkg::*;

	localparam int CONV_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int NDIG   = ((CONV_W * 1233) >> 12) + 1;
	localparam int DIDX_W = $clog2(NDIG);

	rne_state_t            state_q, state_d;
	logic [ROMAN_W-1:0]    rem_q;
	logic [SYM_IDX_W-1:0]  idx_q;
	logic [DIDX_W-1:0]     dig_idx_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_empty_q;
	logic                  out_last_q;

	logic [CONV_W-1:0]     value_w;
	logic                  is_zero;
	logic                  is_big;
	logic [ROMAN_W-1:0]    weight;
	logic [ROMAN_W-1:0]    rem_sub;
	logic                  take;
	logic                  sym_pair;
	logic                  can_load;
	logic                  accept;
	logic                  conv_start;
	logic                  out_load;
	logic [7:0]            out_char;
	logic                  out_empty;
	logic                  out_last;
	logic [3:0]            digit_sel;

	rne_conv_stat_t        conv_stat;
	logic [NDIG*4-1:0]     conv_digits;
	logic [DIDX_W-1:0]     conv_msd;

	// request decode
	assign value_w = s_axis_tdata[CONV_W-1:0];
	assign is_zero = (value_w == '0);
	assign is_big  = (value_w > CONV_W'(ROMAN_LIMIT));
	assign accept  = s_axis_tvalid && s_axis_tready;

	// shared compare/subtract unit against the current table entry
	assign weight   = rne_weight(idx_q);
	assign take     = (rem_q >= weight);
	assign rem_sub  = rem_q - weight;
	assign sym_pair = (rne_second(idx_q) != NO_CHAR);

	assign can_load  = !out_valid_q || m_axis_tready;
	assign digit_sel = conv_digits[dig_idx_q*4 +: 4];

	// decimal converter
	rne_bcd_conv #(
		.W      (CONV_W),
		.NDIG   (NDIG),
		.DIDX_W (DIDX_W)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (value_w),
		.stat   (conv_stat),
		.digits (conv_digits),
		.msd    (conv_msd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (is_zero) begin
						state_d = ST_EMPTY;
					end else if (is_big) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_ROMAN;
					end
				end
			end
			ST_EMPTY: begin
				if (can_load) state_d = ST_IDLE;
			end
			ST_ROMAN: begin
				if (take && can_load) begin
					if (sym_pair) begin
						state_d = ST_PAIR;
					end else if (rem_sub == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PAIR: begin
				if (can_load) state_d = (rem_q == '0) ? ST_IDLE : ST_ROMAN;
			end
			ST_CONV: begin
				if (conv_stat.done) state_d = ST_DIGITS;
			end
			ST_DIGITS: begin
				if (can_load && dig_idx_q == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		conv_start    = 1'b0;
		out_load      = 1'b0;
		out_char      = NO_CHAR;
		out_empty     = 1'b0;
		out_last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				conv_start    = s_axis_tvalid && is_big;
			end
			ST_EMPTY: begin
				out_load  = can_load;
				out_empty = 1'b1;
				out_last  = 1'b1;
			end
			ST_ROMAN: begin
				out_load = take && can_load;
				out_char = rne_first(idx_q);
				out_last = !sym_pair && (rem_sub == '0);
			end
			ST_PAIR: begin
				out_load = can_load;
				out_char = rne_second(idx_q);
				out_last = (rem_q == '0);
			end
			ST_CONV: begin
				out_load = 1'b0;
			end
			ST_DIGITS: begin
				out_load = can_load;
				out_char = ASCII_ZERO | {4'd0, digit_sel};
				out_last = (dig_idx_q == '0);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			dig_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == ST_ROMAN && !take) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_CONV && conv_stat.done) begin
				dig_idx_q <= conv_msd;
			end else if (state_q == ST_DIGITS && can_load) begin
				dig_idx_q <= dig_idx_q - 1'b1;
			end
		end
	end

	// remaining roman value
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= value_w[ROMAN_W-1:0];
		end else if (state_q == ST_ROMAN && take && can_load) begin
			rem_q <= rem_sub;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q  <= out_char;
			out_empty_q <= out_empty;
			out_last_q  <= out_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tuser  = out_empty_q;
	assign m_axis_tlast  = out_last_q;

	// roman loop never runs on an exhausted value
	a_roman_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROMAN |-> rem_q != '0)
		else $error("roman state with zero remainder");

	// table walk stays inside the table
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROMAN |-> idx_q < SYM_IDX_W'(NUM_SYMS))
		else $error("symbol index past table end");

	// converter finishes only while the sequencer waits on it
	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		conv_stat.done |-> state_q == ST_CONV)
		else $error("converter done outside conversion");

	// decimal run starts on a nonzero digit
	a_msd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS && $past(state_q) == ST_CONV) |-> digit_sel != 4'd0)
		else $error("leading zero digit");

endmodule
